@@ hw/rtl/phs_pkg.sv @@
// Package for the per-host limited oldest-first scheduler.
// Port widths, command codes and the structs passed between the cells,
// the counter block and the top level. No dependencies.
`default_nettype none

package phs_pkg;

   // Default table sizes
   localparam int JOBS_DEFAULT  = 32;
   localparam int HOSTS_DEFAULT = 16;

   // Fixed port widths
   localparam int KIND_W    = 2;
   localparam int SLOT_ID_W = 5;
   localparam int HOST_ID_W = 4;
   localparam int STATUS_W  = 2;
   localparam int LIMIT_W   = 6;
   localparam int CSR_IDX_W = 1;
   localparam int SERIAL_W  = 32;

   // Internal carriers sized for the largest table (JOBS, HOSTS up to 256)
   localparam int SLOT_MAX_W = 8;
   localparam int HOST_MAX_W = 8;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_ENQ    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_SCHEDULED = 2'd3;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WORKERS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PER_HOST = 1'd1;

   // Table update broadcast to every cell
   typedef struct packed {
      logic                  enq;
      logic                  rem;
      logic                  run;
      logic [SLOT_MAX_W-1:0] slot;
      logic [HOST_MAX_W-1:0] host;
      logic [SERIAL_W-1:0]   serial;
   } cmd_type;

   // Best candidate so far, handed from cell to cell
   typedef struct packed {
      logic                  found;
      logic [SERIAL_W-1:0]   serial;
      logic [SLOT_MAX_W-1:0] slot;
      logic [HOST_MAX_W-1:0] host;
   } token_type;

   // Entry view for the slot lookup on enqueue and remove
   typedef struct packed {
      logic                  valid;
      logic                  running;
      logic [HOST_MAX_W-1:0] host;
   } entry_type;

   // Running count update
   typedef struct packed {
      logic                  inc;
      logic                  dec;
      logic [HOST_MAX_W-1:0] host;
   } cnt_upd_type;

endpackage

`default_nettype wire

@@ hw/rtl/phs_cell.sv @@
// One job table entry of the scheduler chain, with its stage of the
// oldest-first search. Depends on phs_pkg.
`default_nettype none

module phs_cell
   import phs_pkg::*;
#(
   parameter int JOBS  = JOBS_DEFAULT,
   parameter int HOSTS = HOSTS_DEFAULT,
   parameter int IDX   = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   input  wire logic [HOSTS-1:0] host_full,
   input  wire token_type        token_in,
   output token_type             token_out,
   output entry_type             entry
);

   localparam int HW = (HOSTS > 1) ? $clog2(HOSTS) : 1;

   logic                valid_ff;
   logic                running_ff;
   logic [HW-1:0]       host_ff;
   logic [SERIAL_W-1:0] serial_ff;
   token_type           token_ff;
   token_type           token_in_w;
   logic                hit;
   logic                eligible;
   logic                take;

   assign hit = (cmd.slot == SLOT_MAX_W'(IDX));

   // Entry flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         running_ff <= 1'b0;
      end else if (hit) begin
         if (cmd.enq) begin
            valid_ff   <= 1'b1;
            running_ff <= 1'b0;
         end else if (cmd.rem) begin
            valid_ff   <= 1'b0;
            running_ff <= 1'b0;
         end else if (cmd.run) begin
            running_ff <= 1'b1;
         end
      end
   end

   // Entry payload, written on enqueue only
   always_ff @(posedge clock) begin
      if (hit && cmd.enq) begin
         host_ff   <= cmd.host[HW-1:0];
         serial_ff <= cmd.serial;
      end
   end

   // Search stage: strict less-than keeps the lower slot on equal serials
   assign eligible = valid_ff && !running_ff && !host_full[host_ff];
   assign take     = eligible && (!token_in.found || (serial_ff < token_in.serial));

   always_comb begin
      token_in_w = token_in;
      if (take) begin
         token_in_w.found  = 1'b1;
         token_in_w.serial = serial_ff;
         token_in_w.slot   = SLOT_MAX_W'(IDX);
         token_in_w.host   = HOST_MAX_W'(host_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in_w;
      end
   end

   assign token_out     = token_ff;
   assign entry.valid   = valid_ff;
   assign entry.running = running_ff;
   assign entry.host    = HOST_MAX_W'(host_ff);

endmodule

`default_nettype wire

@@ hw/rtl/phs_cnt.sv @@
// Per-host and total running counters of the scheduler, with the limit
// compares that gate the search. Depends on phs_pkg.
`default_nettype none

module phs_cnt
   import phs_pkg::*;
#(
   parameter int JOBS  = JOBS_DEFAULT,
   parameter int HOSTS = HOSTS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cnt_upd_type        upd,
   input  wire logic [LIMIT_W-1:0] host_limit,
   input  wire logic [LIMIT_W-1:0] total_limit,
   output logic [HOSTS-1:0]        host_full,
   output logic                    total_below
);

   localparam int CNT_W = $clog2(JOBS + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   logic [CNT_W-1:0] host_cnt_ff [HOSTS];
   logic [CNT_W-1:0] total_cnt_ff;

   // One counter per host; decrements saturate at zero
   for (genvar h = 0; h < HOSTS; h++) begin : g_host
      logic sel;
      assign sel = (upd.host == HOST_MAX_W'(h));

      always_ff @(posedge clock) begin
         if (reset) begin
            host_cnt_ff[h] <= '0;
         end else if (sel && upd.inc) begin
            host_cnt_ff[h] <= host_cnt_ff[h] + CNT_W'(1);
         end else if (sel && upd.dec && (host_cnt_ff[h] != '0)) begin
            host_cnt_ff[h] <= host_cnt_ff[h] - CNT_W'(1);
         end
      end

      assign host_full[h] = (CMP_W'(host_cnt_ff[h]) >= CMP_W'(host_limit));
   end

   // Total running count
   always_ff @(posedge clock) begin
      if (reset) begin
         total_cnt_ff <= '0;
      end else if (upd.inc) begin
         total_cnt_ff <= total_cnt_ff + CNT_W'(1);
      end else if (upd.dec && (total_cnt_ff != '0)) begin
         total_cnt_ff <= total_cnt_ff - CNT_W'(1);
      end
   end

   assign total_below = (CMP_W'(total_cnt_ff) < CMP_W'(total_limit));

endmodule

`default_nettype wire

@@ hw/rtl/per_host_limited_oldest_first_scheduler_top.sv @@
// Top level of the per-host limited oldest-first scheduler: request decode,
// sequencer, CSRs and response register. Depends on phs_pkg, phs_cell, phs_cnt.
//
// Enqueue, remove and unused-kind requests finish in the cycle they are
// accepted; the response is registered and shows up the next cycle. A start
// request passes its search token down the chain of JOBS entry cells, one
// cell per cycle, and then commits in the finish state once the response
// register is free. A new request is taken when the block is idle and,
// unless it is a start request, the response register is free; a start
// request is taken even while a previous response waits on rsp_ready.
// No clearing pass is needed after reset.
`default_nettype none

module per_host_limited_oldest_first_scheduler_top
   import phs_pkg::*;
#(
   parameter int JOBS  = JOBS_DEFAULT,
   parameter int HOSTS = HOSTS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [SLOT_ID_W-1:0] req_job_slot,
   input  wire logic [HOST_ID_W-1:0] req_host_id,
   // response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic                      rsp_started,
   output logic [SLOT_ID_W-1:0]      rsp_started_slot,
   output logic [HOST_ID_W-1:0]      rsp_started_host,
   output logic                      rsp_freed_running,
   // CSR write port
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [LIMIT_W-1:0]   csr_wdata
);

   localparam int SW = (JOBS > 1) ? $clog2(JOBS) : 1;
   localparam int HW = (HOSTS > 1) ? $clog2(HOSTS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [SW-1:0]       scan_cnt_ff, scan_cnt_in;
   logic [SERIAL_W-1:0] next_serial_ff, next_serial_in;
   logic [SERIAL_W-1:0] serial_inc;
   logic [LIMIT_W-1:0]  max_workers_ff;
   logic [LIMIT_W-1:0]  max_per_host_ff;
   logic [LIMIT_W-1:0]  host_limit;
   logic [LIMIT_W-1:0]  total_limit;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_started_ff, rsp_started_in;
   logic [SW-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [HW-1:0]       rsp_host_ff, rsp_host_in;
   logic                rsp_freed_ff, rsp_freed_in;
   logic                out_load;
   logic                out_free;
   logic                req_accept;

   logic [SW-1:0]       slot_tbl [2**SLOT_ID_W];
   logic [HW-1:0]       host_tbl [2**HOST_ID_W];
   logic [SW-1:0]       slot_idx;
   logic [HW-1:0]       host_idx;

   cmd_type             cmd;
   cnt_upd_type         upd;
   token_type           tokens [JOBS+1];
   token_type           best;
   entry_type           entries [JOBS];
   entry_type           sel_entry;
   logic [HOSTS-1:0]    host_full;
   logic                total_below;

   // Index reduction tables (slot mod JOBS, host mod HOSTS)
   for (genvar v = 0; v < 2**SLOT_ID_W; v++) begin : g_slot_tbl
      assign slot_tbl[v] = SW'(v % JOBS);
   end
   for (genvar v = 0; v < 2**HOST_ID_W; v++) begin : g_host_tbl
      assign host_tbl[v] = HW'(v % HOSTS);
   end

   assign slot_idx  = slot_tbl[req_job_slot];
   assign host_idx  = host_tbl[req_host_id];
   assign sel_entry = entries[slot_idx];

   // CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         max_workers_ff  <= LIMIT_W'(1);
         max_per_host_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_WORKERS:  max_workers_ff  <= csr_wdata;
            CSR_MAX_PER_HOST: max_per_host_ff <= csr_wdata;
         endcase
      end
   end

   // Effective limits
   always_comb begin
      if (max_per_host_ff == '0) begin
         host_limit = max_workers_ff;
      end else if (max_per_host_ff < max_workers_ff) begin
         host_limit = max_per_host_ff;
      end else begin
         host_limit = max_workers_ff;
      end
      total_limit = (max_workers_ff > host_limit) ? max_workers_ff : host_limit;
   end

   // Entry cell chain; cell 0 starts from an empty token
   assign tokens[0] = '0;
   for (genvar i = 0; i < JOBS; i++) begin : g_cell
      phs_cell #(
         .JOBS  (JOBS),
         .HOSTS (HOSTS),
         .IDX   (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .host_full (host_full),
         .token_in  (tokens[i]),
         .token_out (tokens[i+1]),
         .entry     (entries[i])
      );
   end
   assign best = tokens[JOBS];

   phs_cnt #(
      .JOBS  (JOBS),
      .HOSTS (HOSTS)
   ) u_cnt (
      .clock       (clock),
      .reset       (reset),
      .upd         (upd),
      .host_limit  (host_limit),
      .total_limit (total_limit),
      .host_full   (host_full),
      .total_below (total_below)
   );

   // Handshake
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && (out_free || (req_kind == KIND_START));
   assign req_accept = req_valid && req_ready;

   // Serial counter skips zero on wrap
   always_comb begin
      serial_inc = next_serial_ff + SERIAL_W'(1);
      if (serial_inc == '0) begin
         serial_inc = SERIAL_W'(1);
      end
   end

   // Sequencer and request decode
   always_comb begin
      state_in       = state_ff;
      scan_cnt_in    = scan_cnt_ff;
      next_serial_in = next_serial_ff;
      cmd            = '0;
      upd            = '0;
      out_load       = 1'b0;
      rsp_status_in  = STATUS_DONE;
      rsp_started_in = 1'b0;
      rsp_slot_in    = '0;
      rsp_host_in    = '0;
      rsp_freed_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.slot = SLOT_MAX_W'(slot_idx);
               cmd.host = HOST_MAX_W'(host_idx);
               cmd.serial = next_serial_ff;
               unique case (req_kind)
                  KIND_ENQ: begin
                     out_load = 1'b1;
                     if (sel_entry.valid) begin
                        rsp_status_in = STATUS_SCHEDULED;
                     end else begin
                        cmd.enq        = 1'b1;
                        next_serial_in = serial_inc;
                     end
                  end
                  KIND_REMOVE: begin
                     out_load = 1'b1;
                     if (!sel_entry.valid) begin
                        rsp_status_in = STATUS_UNKNOWN;
                     end else begin
                        cmd.rem = 1'b1;
                        if (sel_entry.running) begin
                           upd.dec      = 1'b1;
                           upd.host     = sel_entry.host;
                           rsp_freed_in = 1'b1;
                        end
                     end
                  end
                  KIND_START: begin
                     state_in    = ST_SCAN;
                     scan_cnt_in = '0;
                  end
                  default: begin
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + SW'(1);
            if (scan_cnt_ff == SW'(JOBS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               if (total_below && best.found) begin
                  cmd.run        = 1'b1;
                  cmd.slot       = best.slot;
                  upd.inc        = 1'b1;
                  upd.host       = best.host;
                  rsp_started_in = 1'b1;
                  rsp_slot_in    = best.slot[SW-1:0];
                  rsp_host_in    = best.host[HW-1:0];
               end else begin
                  rsp_status_in = STATUS_NONE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         scan_cnt_ff    <= '0;
         next_serial_ff <= SERIAL_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         scan_cnt_ff    <= scan_cnt_in;
         next_serial_ff <= next_serial_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_started_ff <= rsp_started_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_host_ff    <= rsp_host_in;
         rsp_freed_ff   <= rsp_freed_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_started       = rsp_started_ff;
   assign rsp_started_slot  = SLOT_ID_W'(rsp_slot_ff);
   assign rsp_started_host  = HOST_ID_W'(rsp_host_ff);
   assign rsp_freed_running = rsp_freed_ff;

   // A launched job must be a queued entry
   a_start_queued: assert property (@(posedge clock) disable iff (reset)
      cmd.run |-> (entries[best.slot[SW-1:0]].valid && !entries[best.slot[SW-1:0]].running))
      else $error("start picked an entry that is not queued");

   // Enqueue never overwrites a live entry
   a_enq_free: assert property (@(posedge clock) disable iff (reset)
      cmd.enq |-> !entries[cmd.slot[SW-1:0]].valid)
      else $error("enqueue hit a valid entry");

   // Serial zero is never issued
   a_serial_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_serial_ff != '0)
      else $error("next serial is zero");

   // A search always begins at the first cell
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_SCAN) |-> (scan_cnt_ff == '0))
      else $error("scan entered with nonzero count");

   // A start result never reports a status other than done
   a_started_done: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_started_in) |=> (rsp_status_ff == STATUS_DONE))
      else $error("started response with error status");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for per_host_limited_oldest_first_scheduler_top.
// Holds its own job-table predictor and compares every response against it.
// Depends on phs_pkg and the scheduler RTL only.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import phs_pkg::*;

   localparam int NJOBS       = JOBS_DEFAULT;
   localparam int NHOSTS      = HOSTS_DEFAULT;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 40;

   // kind 3 has no name in the package; the block ignores it
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 started;
      logic [SLOT_ID_W-1:0] slot;
      logic [HOST_ID_W-1:0] host;
      logic                 freed;
   } sched_result_type;

   // DUT connections
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [KIND_W-1:0]    req_kind = KIND_ENQ;
   logic [SLOT_ID_W-1:0] req_job_slot = '0;
   logic [HOST_ID_W-1:0] req_host_id = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_started;
   logic [SLOT_ID_W-1:0] rsp_started_slot;
   logic [HOST_ID_W-1:0] rsp_started_host;
   logic                 rsp_freed_running;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MAX_WORKERS;
   logic [LIMIT_W-1:0]   csr_wdata = '0;

   // predicted job table, counts and limits
   logic [LIMIT_W-1:0]   lim_max_workers = 6'd1;
   logic [LIMIT_W-1:0]   lim_max_per_host = 6'd0;
   bit                   job_valid [NJOBS];
   bit                   job_running [NJOBS];
   logic [HOST_ID_W-1:0] job_host [NJOBS];
   logic [SERIAL_W-1:0]  job_serial [NJOBS];
   int                   host_running [NHOSTS];
   int                   total_running = 0;
   logic [SERIAL_W-1:0]  next_serial = SERIAL_W'(1);

   sched_result_type     pending_results [$];
   sched_result_type     checked_want;

   // bookkeeping
   int mismatches = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int jobs_launched = 0;
   int start_refusals = 0;
   int limit_writes = 0;
   int stalled_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   per_host_limited_oldest_first_scheduler_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_job_slot      (req_job_slot),
      .req_host_id       (req_host_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_started       (rsp_started),
      .rsp_started_slot  (rsp_started_slot),
      .rsp_started_host  (rsp_started_host),
      .rsp_freed_running (rsp_freed_running),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one request to the predicted table and return the response it earns
   function automatic sched_result_type schedule_step(input logic [KIND_W-1:0] kind,
                                                      input logic [SLOT_ID_W-1:0] slot,
                                                      input logic [HOST_ID_W-1:0] host);
      sched_result_type res;
      int               plim;
      int               tlim;
      int               best;
      bit               found;
      res   = '0;
      best  = 0;
      found = 1'b0;
      // zero per-host limit means "same as total"; otherwise clamp to total
      if (lim_max_per_host == 0)
         plim = int'(lim_max_workers);
      else
         plim = (lim_max_per_host < lim_max_workers) ? int'(lim_max_per_host)
                                                     : int'(lim_max_workers);
      tlim = (int'(lim_max_workers) > plim) ? int'(lim_max_workers) : plim;
      case (kind)
         KIND_ENQ: begin
            if (job_valid[slot]) begin
               res.status = STATUS_SCHEDULED;
            end else begin
               job_valid[slot]   = 1'b1;
               job_running[slot] = 1'b0;
               job_host[slot]    = host;
               job_serial[slot]  = next_serial;
               next_serial = next_serial + SERIAL_W'(1);
               if (next_serial == 0)
                  next_serial = SERIAL_W'(1);
            end
         end
         KIND_REMOVE: begin
            if (!job_valid[slot]) begin
               res.status = STATUS_UNKNOWN;
            end else begin
               if (job_running[slot]) begin
                  if (host_running[job_host[slot]] > 0)
                     host_running[job_host[slot]]--;
                  if (total_running > 0)
                     total_running--;
                  res.freed = 1'b1;
               end
               job_valid[slot]   = 1'b0;
               job_running[slot] = 1'b0;
            end
         end
         KIND_START: begin
            // oldest queued job on a host still under its limit
            if (total_running < tlim) begin
               for (int i = 0; i < NJOBS; i++) begin
                  if (job_valid[i] && !job_running[i] && host_running[job_host[i]] < plim &&
                      (!found || job_serial[i] < job_serial[best])) begin
                     best  = i;
                     found = 1'b1;
                  end
               end
            end
            if (found) begin
               job_running[best] = 1'b1;
               host_running[job_host[best]]++;
               total_running++;
               res.started = 1'b1;
               res.slot    = SLOT_ID_W'(best);
               res.host    = job_host[best];
               jobs_launched++;
            end else begin
               res.status = STATUS_NONE;
               start_refusals++;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Find a slot in the wanted state, scanning from a random point; -1 if none
   function automatic int find_slot(input bit want_valid, input bit want_running);
      int base;
      int s;
      base = int'($urandom_range(NJOBS - 1));
      for (int i = 0; i < NJOBS; i++) begin
         s = (base + i) % NJOBS;
         if (job_valid[s] == want_valid && (!want_running || job_running[s]))
            return s;
      end
      return -1;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // Offer one request; entered and left at a falling edge, valid left high
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [SLOT_ID_W-1:0] slot,
                               input logic [HOST_ID_W-1:0] host);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_kind     = kind;
      req_job_slot = slot;
      req_host_id  = host;
      do
         @(posedge clock);
      while (!req_ready);
      pending_results.push_back(schedule_step(kind, slot, host));
      requests_sent++;
      @(negedge clock);
   endtask

   // Lower valid and wait until every outstanding response has come back
   task automatic wait_for_idle;
      req_valid = 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      if (idx == CSR_MAX_WORKERS)
         lim_max_workers = value;
      else
         lim_max_per_host = value;
      limit_writes++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic set_limits(input logic [LIMIT_W-1:0] workers, input logic [LIMIT_W-1:0] per_host);
      wait_for_idle;
      write_csr(CSR_MAX_WORKERS, workers);
      write_csr(CSR_MAX_PER_HOST, per_host);
   endtask

   // Reset limits (one worker total): ordering, duplicates, unknown removes
   task automatic test_reset_defaults;
      send_request(KIND_START, 5'd0, 4'd0);
      send_request(KIND_REMOVE, 5'd9, 4'd0);
      send_request(KIND_UNUSED, 5'd31, 4'd15);
      send_request(KIND_ENQ, 5'd0, 4'd0);
      send_request(KIND_ENQ, 5'd0, 4'd7);
      send_request(KIND_ENQ, 5'd31, 4'd15);
      send_request(KIND_START, 5'd31, 4'd15);
      send_request(KIND_START, 5'd0, 4'd0);
      send_request(KIND_REMOVE, 5'd0, 4'd0);
      send_request(KIND_START, 5'd0, 4'd0);
      send_request(KIND_REMOVE, 5'd31, 4'd0);
      send_request(KIND_REMOVE, 5'd31, 4'd0);
   endtask

   // Zero total, maximum total, per-host cap, and per-host above total
   task automatic test_limit_settings;
      set_limits(6'd0, 6'd0);
      send_request(KIND_ENQ, 5'd5, 4'd3);
      send_request(KIND_START, 5'd0, 4'd0);
      set_limits(6'd63, 6'd0);
      send_request(KIND_START, 5'd0, 4'd0);
      set_limits(6'd2, 6'd1);
      send_request(KIND_ENQ, 5'd6, 4'd3);
      send_request(KIND_ENQ, 5'd7, 4'd4);
      send_request(KIND_START, 5'd0, 4'd0);
      send_request(KIND_START, 5'd0, 4'd0);
      set_limits(6'd2, 6'd40);
      send_request(KIND_REMOVE, 5'd7, 4'd0);
      send_request(KIND_START, 5'd0, 4'd0);
      send_request(KIND_REMOVE, 5'd5, 4'd0);
      send_request(KIND_REMOVE, 5'd6, 4'd0);
      wait_for_idle;
   endtask

   // Receiver holds off for a long stretch while requests keep coming
   task automatic test_full_backpressure;
      set_limits(6'd4, 6'd2);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      for (int i = 0; i < 40; i++) begin
         if (i % 3 == 2)
            send_request(KIND_START, SLOT_ID_W'($urandom_range(31)),
                         HOST_ID_W'($urandom_range(15)));
         else
            send_request((i % 3 == 0) ? KIND_ENQ : KIND_REMOVE,
                         SLOT_ID_W'($urandom_range(31)), HOST_ID_W'($urandom_range(3)));
      end
      wait_for_idle;
   endtask

   task automatic pick_random_limits;
      logic [LIMIT_W-1:0] workers;
      logic [LIMIT_W-1:0] per_host;
      case ($urandom_range(9))
         0: begin
            workers  = '0;
            per_host = LIMIT_W'($urandom_range(63));
         end
         1: begin
            workers  = LIMIT_W'(63);
            per_host = '0;
         end
         2: begin
            workers  = LIMIT_W'(1);
            per_host = LIMIT_W'($urandom_range(2));
         end
         3: begin
            workers  = LIMIT_W'($urandom_range(63, 1));
            per_host = LIMIT_W'(63);
         end
         default: begin
            workers  = LIMIT_W'($urandom_range(8, 1));
            per_host = LIMIT_W'($urandom_range(int'(workers) + 2, 0));
         end
      endcase
      set_limits(workers, per_host);
   endtask

   // Mostly well-formed traffic: enqueue to free slots, remove live jobs, start
   task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
      int                   r;
      int                   s;
      logic [KIND_W-1:0]    kind;
      logic [SLOT_ID_W-1:0] slot;
      logic [HOST_ID_W-1:0] host;
      for (int i = 0; i < n_items; i++) begin
         if (i % 80 == 0) begin
            pick_random_limits();
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
         end
         r    = int'($urandom_range(99));
         slot = SLOT_ID_W'($urandom_range(31));
         // half the jobs crowd onto a few hosts so the per-host limit bites
         host = $urandom_range(1) ? HOST_ID_W'($urandom_range(3))
                                  : HOST_ID_W'($urandom_range(15));
         if (r < 36) begin
            kind = KIND_ENQ;
            if ($urandom_range(99) < 85) begin
               s = find_slot(1'b0, 1'b0);
               if (s >= 0)
                  slot = SLOT_ID_W'(s);
            end
         end else if (r < 64) begin
            kind = KIND_START;
         end else if (r < 94) begin
            kind = KIND_REMOVE;
            if ($urandom_range(99) < 85) begin
               s = find_slot(1'b1, 1'($urandom_range(1)));
               if (s < 0)
                  s = find_slot(1'b1, 1'b0);
               if (s >= 0)
                  slot = SLOT_ID_W'(s);
            end
         end else if (r < 97) begin
            kind = KIND_UNUSED;
         end else begin
            kind = KIND_W'($urandom_range(3));
         end
         send_request(kind, slot, host);
      end
      wait_for_idle;
   endtask

   // Receiver: random stalls, plus the long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response checker: oldest prediction against each accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            checked_want = pending_results.pop_front();
            if (rsp_status !== checked_want.status)
               report_mismatch($sformatf("status: want %0d got %0d",
                                         checked_want.status, rsp_status));
            if (rsp_started !== checked_want.started)
               report_mismatch($sformatf("started: want %0d got %0d",
                                         checked_want.started, rsp_started));
            if (rsp_started_slot !== checked_want.slot)
               report_mismatch($sformatf("started_slot: want %0d got %0d",
                                         checked_want.slot, rsp_started_slot));
            if (rsp_started_host !== checked_want.host)
               report_mismatch($sformatf("started_host: want %0d got %0d",
                                         checked_want.host, rsp_started_host));
            if (rsp_freed_running !== checked_want.freed)
               report_mismatch($sformatf("freed_running: want %0d got %0d",
                                         checked_want.freed, rsp_freed_running));
         end
      end
   end

   // Watchdog on cycles in which neither channel moves
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stalled_cycles = 0;
      else
         stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, pending_results.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NJOBS; i++) begin
         job_valid[i]   = 1'b0;
         job_running[i] = 1'b0;
      end
      for (int i = 0; i < NHOSTS; i++)
         host_running[i] = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_limit_settings();
      test_full_backpressure();
      test_random_traffic(320, 7, 50);
      test_random_traffic(320, 50, 7);
      test_random_traffic(320, 0, 0);

      wait_for_idle;
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));

      $display("covered %0d requests and %0d responses over %0d limit writes",
               requests_sent, responses_seen, limit_writes);
      $display("jobs launched: %0d, starts refused: %0d, mismatches: %0d",
               jobs_launched, start_refusals, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
